// ----- rtl/core/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// Trial division primality package
// Shared constants, state encoding and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

  // Default operand width.
  localparam int unsigned WIDTH_DEF = 32;

  // Trial divisor constants.
  localparam int unsigned FIRST_DIV = 5;
  localparam int unsigned DIV_STEP  = 6;
  localparam int unsigned PAIR_GAP  = 2;
  localparam int unsigned SMALL_DIV = 3;

  // Divisor choice when a division starts.
  typedef enum logic [1:0] {
    SEL_THREE,
    SEL_D,
    SEL_D_PLUS2,
    SEL_D_NEXT
  } div_sel_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV3,
    ST_CHK3,
    ST_DIVD,
    ST_CHKD,
    ST_DIVD2,
    ST_CHKD2,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     d_init;
    logic     start;
    div_sel_t sel;
    logic     step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_le1;
    logic n_le3;
    logic n_even;
    logic div_last;
    logic rem_zero;
    logic bound_ok;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/trial_division_primality.sv -----
// Numbers 0..3 and even numbers are decided without a division, a number that
// 3 divides after one division, and a prime after division by 3 and by each
// divisor pair (i, i + 2) until the divisor passes its square root.
// One number at a time; the single one-bit-per-cycle divider is shared by
// every trial divisor.
// Reset: synchronous, active low; clears the controller and the output beat.
// ----------------------------------------------------------------------------
// Trial division primality tester
// Reports whether an unsigned number is prime by trial division over 3 and
// the divisor pairs 6k - 1, 6k + 1.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_primality #(
  parameter int unsigned WIDTH = tdp_pkg::WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] in_number,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_is_prime
);

  tdp_pkg::cmd_t cmd;
  tdp_pkg::sts_t sts;

  // Sequencer and handshakes.
  tdp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Operand registers and the shared divider.
  tdp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .number (in_number),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire

// ----- rtl/core/tdp_dp.sv -----
// ----------------------------------------------------------------------------
// Trial division primality datapath
// Holds the number under test and the trial divisor, and runs a restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_dp #(
  parameter int unsigned WIDTH = tdp_pkg::WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [WIDTH-1:0] number,
  input  wire tdp_pkg::cmd_t cmd,
  output tdp_pkg::sts_t      sts
);

  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] n_r;
  logic [WIDTH-1:0] d_r,   d_nxt;
  logic [WIDTH-1:0] div_r, div_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH+1:0] diff;
  logic [WIDTH-1:0] d_plus2;
  logic [WIDTH-1:0] d_next;

  assign d_plus2 = d_r + WIDTH'(tdp_pkg::PAIR_GAP);
  assign d_next  = d_r + WIDTH'(tdp_pkg::DIV_STEP);

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign diff = {1'b0, rem_r, quo_r[WIDTH-1]} - {2'b00, div_r};

  // Next state of the divisor, the divider and the step counter.
  always_comb begin
    d_nxt   = d_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (cmd.d_init) begin
      d_nxt = WIDTH'(tdp_pkg::FIRST_DIV);
    end
    if (cmd.start) begin
      rem_nxt = '0;
      quo_nxt = n_r;
      cnt_nxt = '0;
      unique case (cmd.sel)
        tdp_pkg::SEL_THREE:   div_nxt = WIDTH'(tdp_pkg::SMALL_DIV);
        tdp_pkg::SEL_D:       div_nxt = d_r;
        tdp_pkg::SEL_D_PLUS2: div_nxt = d_plus2;
        tdp_pkg::SEL_D_NEXT: begin
          div_nxt = d_next;
          d_nxt   = d_next;
        end
        default:              div_nxt = d_r;
      endcase
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (diff[WIDTH+1]) begin
        rem_nxt = {rem_r[WIDTH-2:0], quo_r[WIDTH-1]};
        quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      end else begin
        rem_nxt = diff[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
      end
    end
  end

  // Datapath registers carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= number;
    end
    d_r   <= d_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  // Status toward the controller. The last-step flag is only read while the
  // controller is stepping a division.
  always_comb begin
    sts.n_le1    = (n_r <= WIDTH'(1));
    sts.n_le3    = (n_r <= WIDTH'(tdp_pkg::SMALL_DIV));
    sts.n_even   = ~n_r[0];
    sts.div_last = (cnt_r == CNT_W'(WIDTH - 1));
    sts.rem_zero = (rem_r == '0);
    sts.bound_ok = (div_r <= quo_r);
  end

  // Starting a division loads the dividend and clears the remainder.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (quo_r == n_r) && (rem_r == '0))
    else $error("divider did not load the dividend");

  // A completed division leaves a remainder below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && sts.div_last && (div_r != '0) |=> (rem_r < div_r))
    else $error("remainder not below divisor");

  // The counter only wraps through the final step of a division.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !sts.div_last |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("step counter skipped");

endmodule

`default_nettype wire

// ----- rtl/core/tdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Trial division primality controller
// Sequences the small-value checks, the division by three and the pairs of
// trial divisions, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_is_prime,
  output tdp_pkg::cmd_t      cmd,
  input  wire tdp_pkg::sts_t sts
);

  tdp_pkg::state_t state_r, state_nxt;
  logic res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_is_prime_r;
  logic out_load;

  // State register and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_is_prime_r <= res_r;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    cmd        = '0;
    cmd.sel    = tdp_pkg::SEL_D;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state_r)
      tdp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tdp_pkg::ST_CHECK;
        end
      end
      tdp_pkg::ST_CHECK: begin
        if (sts.n_le1) begin
          res_nxt   = 1'b0;
          state_nxt = tdp_pkg::ST_DONE;
        end else if (sts.n_le3) begin
          res_nxt   = 1'b1;
          state_nxt = tdp_pkg::ST_DONE;
        end else if (sts.n_even) begin
          res_nxt   = 1'b0;
          state_nxt = tdp_pkg::ST_DONE;
        end else begin
          cmd.start  = 1'b1;
          cmd.sel    = tdp_pkg::SEL_THREE;
          cmd.d_init = 1'b1;
          state_nxt  = tdp_pkg::ST_DIV3;
        end
      end
      tdp_pkg::ST_DIV3: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = tdp_pkg::ST_CHK3;
        end
      end
      tdp_pkg::ST_CHK3: begin
        if (sts.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = tdp_pkg::ST_DONE;
        end else begin
          cmd.start = 1'b1;
          cmd.sel   = tdp_pkg::SEL_D;
          state_nxt = tdp_pkg::ST_DIVD;
        end
      end
      tdp_pkg::ST_DIVD: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = tdp_pkg::ST_CHKD;
        end
      end
      tdp_pkg::ST_CHKD: begin
        // Past the square root with no divisor found: the number is prime.
        if (!sts.bound_ok) begin
          res_nxt   = 1'b1;
          state_nxt = tdp_pkg::ST_DONE;
        end else if (sts.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = tdp_pkg::ST_DONE;
        end else begin
          cmd.start = 1'b1;
          cmd.sel   = tdp_pkg::SEL_D_PLUS2;
          state_nxt = tdp_pkg::ST_DIVD2;
        end
      end
      tdp_pkg::ST_DIVD2: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = tdp_pkg::ST_CHKD2;
        end
      end
      tdp_pkg::ST_CHKD2: begin
        if (sts.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = tdp_pkg::ST_DONE;
        end else begin
          cmd.start = 1'b1;
          cmd.sel   = tdp_pkg::SEL_D_NEXT;
          state_nxt = tdp_pkg::ST_DIVD;
        end
      end
      tdp_pkg::ST_DONE: begin
        // Hand the verdict to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = tdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdp_pkg::ST_IDLE;
      end
    endcase
  end

  // The output register holds a beat until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // An accepted beat is always examined on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == tdp_pkg::ST_CHECK)
    else $error("accepted beat not examined");

  // Running past the square root always ends with a prime verdict.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdp_pkg::ST_CHKD) && !sts.bound_ok
    |=> (state_r == tdp_pkg::ST_DONE) && res_r)
    else $error("bound exit did not report prime");

  // A verdict is only loaded when the output register has room.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || !out_stall)
    else $error("result overwrote a pending beat");

  // The second division of a pair runs to its last step before its check state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdp_pkg::ST_CHKD2) |-> $past(sts.div_last))
    else $error("check state entered mid-division");

endmodule

`default_nettype wire
